// ===== rtl/dcfb_pkg.sv =====
// dcfb_pkg: shared types, codes and the CRC-16/MODBUS byte step for the
// drive command frame builder. No dependencies.
package dcfb_pkg;

	localparam logic [2:0] OP_SET_SPEED = 3'd0;
	localparam logic [2:0] OP_STOP      = 3'd1;
	localparam logic [2:0] OP_FORWARD   = 3'd2;
	localparam logic [2:0] OP_BACKWARD  = 3'd3;
	localparam logic [2:0] OP_RIGHT     = 3'd4;
	localparam logic [2:0] OP_LEFT      = 3'd5;

	localparam logic [7:0]  FRAME_SYNC    = 8'hFF;
	localparam logic [7:0]  FRAME_LENCODE = 8'h07;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam logic [15:0] SPEED_RESET   = 16'd100;

	localparam logic [3:0] IDX_SYNC    = 4'd0;
	localparam logic [3:0] IDX_LENCODE = 4'd1;
	localparam logic [3:0] IDX_LEFT_LO = 4'd2;
	localparam logic [3:0] IDX_LEFT_HI = 4'd3;
	localparam logic [3:0] IDX_RIGHT_LO = 4'd4;
	localparam logic [3:0] IDX_RIGHT_HI = 4'd5;
	localparam logic [3:0] IDX_FLAGS   = 4'd6;
	localparam logic [3:0] IDX_CRC_LO  = 4'd7;
	localparam logic [3:0] IDX_CRC_HI  = 4'd8;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] speed_value;
	} cmd_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic [3:0] byte_index;
		logic       last_byte;
	} frame_t;

	typedef struct packed {
		logic [15:0] left_speed;
		logic [15:0] right_speed;
		logic [7:0]  flags;
	} frame_info_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/dcfb_frame_seq.sv =====
// dcfb_frame_seq: serializes one nine-byte frame into the output register,
// running the CRC one byte per cycle unless stalled. Depends on dcfb_pkg.
module dcfb_frame_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  dcfb_pkg::frame_info_t start_info,
	output logic                 can_start,
	output dcfb_pkg::frame_t     frame,
	output logic                 frame_valid,
	input  logic                 frame_stall
);

	logic                  busy_q;
	logic [3:0]            idx_q;
	logic [15:0]           crc_q;
	dcfb_pkg::frame_info_t info_q;
	dcfb_pkg::frame_t      out_q;
	logic                  out_valid_q;
	logic                  load;
	logic [7:0]            cur_byte;

	assign load      = !out_valid_q || !frame_stall;
	assign can_start = !busy_q || (load && idx_q == dcfb_pkg::IDX_CRC_HI);

	always_comb begin
		case (idx_q)
			dcfb_pkg::IDX_SYNC:     cur_byte = dcfb_pkg::FRAME_SYNC;
			dcfb_pkg::IDX_LENCODE:  cur_byte = dcfb_pkg::FRAME_LENCODE;
			dcfb_pkg::IDX_LEFT_LO:  cur_byte = info_q.left_speed[7:0];
			dcfb_pkg::IDX_LEFT_HI:  cur_byte = info_q.left_speed[15:8];
			dcfb_pkg::IDX_RIGHT_LO: cur_byte = info_q.right_speed[7:0];
			dcfb_pkg::IDX_RIGHT_HI: cur_byte = info_q.right_speed[15:8];
			dcfb_pkg::IDX_FLAGS:    cur_byte = info_q.flags;
			dcfb_pkg::IDX_CRC_LO:   cur_byte = crc_q[7:0];
			dcfb_pkg::IDX_CRC_HI:   cur_byte = crc_q[15:8];
			default:                cur_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= dcfb_pkg::IDX_SYNC;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				if (busy_q) begin
					out_q.frame_byte <= cur_byte;
					out_q.byte_index <= idx_q;
					out_q.last_byte  <= (idx_q == dcfb_pkg::IDX_CRC_HI);
					out_valid_q      <= 1'b1;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= dcfb_pkg::IDX_SYNC;
				crc_q  <= dcfb_pkg::CRC_INIT;
				info_q <= start_info;
			end else if (busy_q && load) begin
				idx_q <= 4'(idx_q + 4'd1);
				if (idx_q >= dcfb_pkg::IDX_LENCODE && idx_q <= dcfb_pkg::IDX_FLAGS) begin
					crc_q <= dcfb_pkg::crc16_byte(crc_q, cur_byte);
				end
				if (idx_q == dcfb_pkg::IDX_CRC_HI) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign frame       = out_q;
	assign frame_valid = out_valid_q;

endmodule

// ===== rtl/drive_command_frame_builder_core.sv =====
// drive_command_frame_builder_core: top level. Holds the drive state and
// decodes commands. Depends on dcfb_pkg and dcfb_frame_seq.
//
// Usage:
//   cmd channel   (cmd, cmd_valid, cmd_stall): one drive command per item.
//   frame channel (frame, frame_valid, frame_stall): one frame byte per item,
//   byte_index 0..8, last_byte set on the CRC high byte.
// A command is registered on entry, then decoded when the frame sequencer
// is free. Set speed and unused codes update state (or not) and produce
// nothing; they are consumed as soon as the sequencer can start. A motion
// command loads the sequencer state, then the first byte is registered in
// the output register; the nine bytes follow one per cycle unless stalled.
// Motion commands are limited by the single byte-wide output register:
// the next command is taken in the same cycle that the last byte is loaded
// into it. Set-speed commands go at one per cycle while the sequencer is idle.
// Reset: speed 100, wheels disabled, both directions ahead, no frame pending.
// A stall on the frame channel freezes the output byte and the sequencer;
// commands back up into the input register and then assert cmd_stall.
module drive_command_frame_builder_core (
	input  logic             clk,
	input  logic             arst_n,
	input  dcfb_pkg::cmd_t   cmd,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	output dcfb_pkg::frame_t frame,
	output logic             frame_valid,
	input  logic             frame_stall
);

	dcfb_pkg::cmd_t        cmd_s1;
	logic                  vld_s1;
	logic [15:0]           speed_q;
	logic                  right_en_q, left_en_q, right_ahead_q, left_ahead_q;
	logic [15:0]           speed_d;
	logic                  right_en_d, left_en_d, right_ahead_d, left_ahead_d;
	logic                  motion;
	logic                  can_start;
	logic                  take;
	logic [15:0]           quarter;
	dcfb_pkg::frame_info_t info;

	assign take      = vld_s1 && can_start;
	assign cmd_stall = vld_s1 && !can_start;
	assign quarter   = {2'b00, speed_q[15:2]};

	always_comb begin
		speed_d       = speed_q;
		right_en_d    = right_en_q;
		left_en_d     = left_en_q;
		right_ahead_d = right_ahead_q;
		left_ahead_d  = left_ahead_q;
		motion        = 1'b0;
		info.left_speed  = speed_q;
		info.right_speed = speed_q;
		case (cmd_s1.operation)
			dcfb_pkg::OP_SET_SPEED: begin
				speed_d = cmd_s1.speed_value;
			end
			dcfb_pkg::OP_STOP: begin
				motion        = 1'b1;
				speed_d       = 16'd0;
				right_en_d    = 1'b0;
				left_en_d     = 1'b0;
				right_ahead_d = 1'b1;
				left_ahead_d  = 1'b1;
				info.left_speed  = 16'd0;
				info.right_speed = 16'd0;
			end
			dcfb_pkg::OP_FORWARD: begin
				motion        = 1'b1;
				right_en_d    = 1'b1;
				left_en_d     = 1'b1;
				right_ahead_d = 1'b1;
				left_ahead_d  = 1'b1;
			end
			dcfb_pkg::OP_BACKWARD: begin
				motion        = 1'b1;
				right_en_d    = 1'b1;
				left_en_d     = 1'b1;
				right_ahead_d = 1'b0;
				left_ahead_d  = 1'b0;
			end
			dcfb_pkg::OP_RIGHT: begin
				motion        = 1'b1;
				right_en_d    = 1'b1;
				left_en_d     = 1'b1;
				right_ahead_d = !left_ahead_q;
				info.right_speed = quarter;
			end
			dcfb_pkg::OP_LEFT: begin
				motion        = 1'b1;
				right_en_d    = 1'b1;
				left_en_d     = 1'b1;
				left_ahead_d  = !right_ahead_q;
				info.left_speed = quarter;
			end
			default: begin
				motion = 1'b0;
			end
		endcase
		info.flags = {left_en_d, left_ahead_d, right_en_d, right_ahead_d, 4'b0000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1        <= 1'b0;
			speed_q       <= dcfb_pkg::SPEED_RESET;
			right_en_q    <= 1'b0;
			left_en_q     <= 1'b0;
			right_ahead_q <= 1'b1;
			left_ahead_q  <= 1'b1;
		end else begin
			if (!cmd_stall) begin
				vld_s1 <= cmd_valid;
				cmd_s1 <= cmd;
			end
			if (take) begin
				speed_q       <= speed_d;
				right_en_q    <= right_en_d;
				left_en_q     <= left_en_d;
				right_ahead_q <= right_ahead_d;
				left_ahead_q  <= left_ahead_d;
			end
		end
	end

	dcfb_frame_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (take && motion),
		.start_info  (info),
		.can_start   (can_start),
		.frame       (frame),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall)
	);

endmodule

// ===== rtl/dcfb_checker.sv =====
// dcfb_checker: port-level assertions for the frame builder, bound to the
// top level below. Depends on dcfb_pkg.
module dcfb_checker (
	input logic             clk,
	input logic             arst_n,
	input dcfb_pkg::frame_t frame,
	input logic             frame_valid,
	input logic             frame_stall
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_stall |=> frame_valid && $stable(frame))
		else $error("frame item changed under stall");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> frame.last_byte == (frame.byte_index == dcfb_pkg::IDX_CRC_HI))
		else $error("last_byte does not match byte_index");

	a_sync: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame.byte_index == dcfb_pkg::IDX_SYNC
		|-> frame.frame_byte == dcfb_pkg::FRAME_SYNC)
		else $error("frame does not open with sync byte");

	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_stall && !frame.last_byte
		|=> frame_valid && frame.byte_index == 4'($past(frame.byte_index) + 4'd1))
		else $error("frame byte missing or out of order");

endmodule

bind drive_command_frame_builder_core dcfb_checker u_dcfb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.frame       (frame),
	.frame_valid (frame_valid),
	.frame_stall (frame_stall)
);
